// ----- design/rsc_pkg.sv -----
package rsc_pkg;

  localparam int DATA_W        = 32;
  localparam int NUM_W         = 31;
  localparam int OP_W          = 3;
  localparam int STATUS_W      = 3;
  localparam int DEPTH_W       = 7;
  localparam int STACK_DEPTH_D = 64;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_PRINT = 3'd3,
    OP_QUIT  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SHOWN     = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_HALTED    = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    push;      // push in_number, spill old top to RAM
    logic    rd_issue;  // read second entry, latch add/sub
    logic    arith_wb;  // combine RAM data with top, pop one
    logic    emit;      // load output register
    logic    set_halt;
    logic    show;      // report top of stack
    status_t status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic halted;
    logic empty;
    logic lt2;
    logic full;
    logic out_busy;
  } dp_status_t;

endpackage

// ----- design/rsc_ram.sv -----
module rsc_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/rsc_ctrl.sv -----
module rsc_ctrl
  import rsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [OP_W-1:0]    in_op,
  output logic               in_stall,
  input  dp_status_t         stat,
  output ctrl_cmd_t          cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_OK;
    in_stall  = (state_r != S_IDLE) || stat.out_busy;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.out_busy) begin
          if (stat.halted) begin
            cmd.emit   = 1'b1;
            cmd.status = ST_HALTED;
          end else begin
            unique case (op_t'(in_op))
              OP_PUSH: begin
                cmd.emit = 1'b1;
                if (stat.full) begin
                  cmd.status = ST_OVERFLOW;
                end else begin
                  cmd.push = 1'b1;
                end
              end
              OP_ADD, OP_SUB: begin
                if (stat.lt2) begin
                  cmd.emit     = 1'b1;
                  cmd.set_halt = 1'b1;
                  cmd.status   = ST_UNDERFLOW;
                end else begin
                  cmd.rd_issue = 1'b1;
                  state_nxt    = S_CALC;
                end
              end
              OP_PRINT: begin
                cmd.emit = 1'b1;
                if (!stat.empty) begin
                  cmd.show   = 1'b1;
                  cmd.status = ST_SHOWN;
                end
              end
              OP_QUIT: begin
                cmd.emit     = 1'b1;
                cmd.set_halt = 1'b1;
              end
              default: begin
                cmd.emit = 1'b1;   // unknown token kind, ignored
              end
            endcase
          end
        end
      end
      S_CALC: begin
        if (!stat.out_busy) begin
          cmd.arith_wb = 1'b1;
          cmd.emit     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/rsc_dp.sv -----
module rsc_dp
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [OP_W-1:0]            in_op,
  input  logic [NUM_W-1:0]           in_number,
  input  logic                       out_stall,
  input  ctrl_cmd_t                  cmd,
  output dp_status_t                 stat,
  output logic                       out_valid,
  output logic [STATUS_W-1:0]        out_status,
  output logic signed [DATA_W-1:0]   out_top_value,
  output logic [DEPTH_W-1:0]         out_depth
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_W-1:0]     tos_r, tos_nxt;
  logic                  halted_r, halted_nxt;
  logic                  sub_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r;
  logic [DATA_W-1:0]     out_top_r;
  logic [DEPTH_W-1:0]    out_depth_r;
  logic [CW-1:0]         cnt_m1, cnt_m2;
  logic [DATA_W-1:0]     rd_data;
  logic [CW+DEPTH_W-1:0] depth_ext;

  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  // entries below the top live in RAM; top of stack is tos_r
  rsc_ram #(
    .W     (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push && (cnt_r != '0)),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (tos_r),
    .re    (cmd.rd_issue),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (rd_data)
  );

  always_comb begin
    cnt_nxt    = cnt_r;
    tos_nxt    = tos_r;
    halted_nxt = halted_r || cmd.set_halt;
    if (cmd.push) begin
      cnt_nxt = cnt_r + CW'(1);
      tos_nxt = {1'b0, in_number};
    end else if (cmd.arith_wb) begin
      cnt_nxt = cnt_m1;
      tos_nxt = sub_r ? (rd_data - tos_r) : (rd_data + tos_r);
    end
  end

  assign depth_ext     = {{DEPTH_W{1'b0}}, cnt_nxt};
  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    if (cmd.rd_issue) begin
      sub_r <= (op_t'(in_op) == OP_SUB);
    end
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_top_r    <= cmd.show ? tos_r : '0;
      out_depth_r  <= depth_ext[DEPTH_W-1:0];
    end
  end

  assign stat.halted   = halted_r;
  assign stat.empty    = (cnt_r == '0);
  assign stat.lt2      = (cnt_r < CW'(2));
  assign stat.full     = (cnt_r == CW'(STACK_DEPTH));
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;

endmodule

// ----- design/rpn_stack_calculator.sv -----
// Reverse-Polish integer calculator.
// Input channel (in_valid/in_stall): one token per request, in_op selects
//   push number, add, subtract, print top or quit; in_number is the value
//   pushed. Result channel (out_valid/out_stall): exactly one request per
//   token with status, top_value (nonzero only when the top is shown) and
//   depth, the entry count after the token.
// The result is registered: for all tokens but a valid add/subtract it appears
//   in the cycle after the token is taken. Add/subtract first pass through S_CALC,
//   as the second operand comes from the stack RAM, whose read port is
//   registered, and no new token is taken in S_CALC. Throughput is one token
//   per cycle while out_stall holds no result, less for add/subtract.
// The top of stack sits in a register; older entries sit in the RAM.
// A full-stack push is dropped with an overflow status; add/subtract on
//   fewer than two entries reports underflow and halts; after quit or an
//   underflow every token is answered with the halted status.
// Reset (rst_n, synchronous) empties the stack and clears the halt; the RAM
//   needs no clearing since only written entries are ever read.
// While out_stall holds a waiting result, in_stall rises and no new token is
//   taken; the waiting result stays unchanged.
module rpn_stack_calculator
  import rsc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OP_W-1:0]          in_op,
  input  logic [NUM_W-1:0]         in_number,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_top_value,
  output logic [DEPTH_W-1:0]       out_depth
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  // sequencing: decode, stall and the add/subtract through S_CALC
  rsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack registers, RAM and the result register
  rsc_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_op         (in_op),
    .in_number     (in_number),
    .out_stall     (out_stall),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_top_value (out_top_value),
    .out_depth     (out_depth)
  );

  // a result never overwrites one still held by the receiver
  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && stat.out_busy))
    else $error("result emitted while output held");

  // after a RAM read is issued the next token must wait
  a_stall_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> in_stall)
    else $error("token taken during add/subtract");

  // halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |=> stat.halted)
    else $error("halt cleared without reset");

  // only a shown top carries a value
  a_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_SHOWN)) |-> (out_top_value == '0))
    else $error("top_value set without shown status");

endmodule

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsc_pkg::*;

  // run shape
  localparam int RESET_CYCLES     = 10;
  localparam int RANDOM_TOKENS    = 2000;    // counted tokens; unused op codes excluded
  localparam int CYCLE_LIMIT      = 500_000; // limit for the watchdog
  localparam int DRAIN_CYCLES     = 20;      // settle time after the last answer
  localparam int LONG_HOLDS       = 2;
  localparam int HOLD_SPACING     = 600;     // tokens between long result-side holds
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int FIRST_UNUSED_OP  = int'(OP_QUIT) + 1;
  localparam int UNUSED_OPS       = (1 << OP_W) - FIRST_UNUSED_OP;

  // one token on the input channel
  typedef struct {
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] number;
  } token_t;

  // one predicted result request
  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
  } answer_t;

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OP_W-1:0]          in_op = '0;
  logic [NUM_W-1:0]         in_number = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_W-1:0]      out_status;
  logic signed [DATA_W-1:0] out_top_value;
  logic [DEPTH_W-1:0]       out_depth;

  rpn_stack_calculator dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_top_value(out_top_value),
    .out_depth    (out_depth)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow calculator: its own copy of the stack, count and halt flag.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH_D];
  int                shadow_count = 0;
  bit                shadow_halted = 1'b0;

  token_t  token_queue[$];  // tokens waiting to be offered
  answer_t answer_queue[$]; // predicted answers, oldest first

  int cycle_count  = 0;
  int tokens_sent  = 0;     // tokens put on the input port
  int tokens_taken = 0;     // tokens accepted by the block
  int error_count  = 0;
  int plan_depth   = 0;     // stack depth implied by the tokens queued so far

  // Applies one token to the shadow stack and returns the answer it causes.
  function automatic answer_t evaluate_token(logic [OP_W-1:0] op, logic [NUM_W-1:0] number);
    answer_t           ans;
    logic [DATA_W-1:0] top;
    logic [DATA_W-1:0] second;
    ans.status    = ST_OK;
    ans.top_value = '0;
    if (shadow_halted) begin
      ans.status = ST_HALTED;
    end else begin
      case (op)
        OP_PUSH: begin
          if (shadow_count < STACK_DEPTH_D) begin
            shadow_stack[shadow_count] = {1'b0, number};
            shadow_count++;
          end else begin
            ans.status = ST_OVERFLOW; // push onto a full stack is dropped
          end
        end
        OP_ADD, OP_SUB: begin
          if (shadow_count < 2) begin
            ans.status    = ST_UNDERFLOW;
            shadow_halted = 1'b1;
          end else begin
            top    = shadow_stack[shadow_count-1];
            second = shadow_stack[shadow_count-2];
            shadow_count--;
            // second plus or minus top, wrapped to the data width
            shadow_stack[shadow_count-1] = (op == OP_ADD) ? second + top : second - top;
          end
        end
        OP_PRINT: begin
          // empty stack: plain ok with a zero value
          if (shadow_count > 0) begin
            ans.status    = ST_SHOWN;
            ans.top_value = shadow_stack[shadow_count-1];
          end
        end
        OP_QUIT: shadow_halted = 1'b1;
        default: ;                    // unused codes: ok, nothing changes
      endcase
    end
    ans.depth = DEPTH_W'(shadow_count);
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic logic [NUM_W-1:0] pick_number();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return NUM_W'($urandom_range(0, 15));
      default: return NUM_W'($urandom);
    endcase
  endfunction

  function automatic void add_token(logic [OP_W-1:0] op, logic [NUM_W-1:0] number);
    token_t tok;
    tok.op     = op;
    tok.number = number;
    token_queue.push_back(tok);
    if (op == OP_PUSH && plan_depth < STACK_DEPTH_D) begin
      plan_depth++;
    end else if ((op == OP_ADD || op == OP_SUB) && plan_depth >= 2) begin
      plan_depth--;
    end
  endfunction

  // Queues one random token that never underflows; returns 0 for unused codes.
  function automatic bit add_random_token(mix_t mix);
    int push_pct;
    int arith_pct;
    int roll;
    case (mix)
      MIX_FILL: begin
        push_pct  = 80;
        arith_pct = 12;
      end
      MIX_DRAIN: begin
        push_pct  = 25;
        arith_pct = 65;
      end
      default: begin
        push_pct  = 45;
        arith_pct = 42;
      end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      add_token(OP_PUSH, pick_number());
    end else if (roll < push_pct + arith_pct && plan_depth >= 2) begin
      add_token($urandom_range(0, 1) ? OP_ADD : OP_SUB, pick_number());
    end else if (roll < 97) begin
      add_token(OP_PRINT, pick_number());
    end else begin
      add_token(OP_W'(FIRST_UNUSED_OP + $urandom_range(0, UNUSED_OPS - 1)), pick_number());
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Sender pause: nothing queued, nothing offered, every answer back.
  task automatic wait_drained();
    while (token_queue.size() != 0 || in_valid || answer_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of tokens with random gaps, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  token_t next_token;
  int     burst_left = 0;
  int     gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || tokens_taken == tokens_sent) begin
      // current request done (or none): next token, or idle
      if (gap_left > 0 || token_queue.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid  <= 1'b0;
        in_op     <= OP_W'($urandom);   // junk while idle
        in_number <= NUM_W'($urandom);
      end else begin
        next_token = token_queue.pop_front();
        tokens_sent++;
        in_valid  <= 1'b1;
        in_op     <= next_token.op;
        in_number <= next_token.number;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result-side stall: a changing pattern, plus long holds that back the
  // block up until it stalls its input while the sender keeps offering.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          stall_tick = 0;
  int          hold_left  = 0;
  int          holds_done = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < LONG_HOLDS && in_valid &&
                 tokens_taken >= HOLD_SPACING * (holds_done + 1)) begin
      hold_left = LONG_HOLD_CYCLES - 1;
      holds_done++;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 256);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= (stall_tick % 3 != 0);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample on the rising edge, check results, then predict.
  // Check comes first so a token taken this edge never answers itself.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    answer_t want;
    cycle_count++;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (answer_queue.size() == 0) begin
          $error("result with nothing expected: status %0d top_value %0d depth %0d",
                 out_status, out_top_value, out_depth);
          error_count++;
        end else begin
          want = answer_queue.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            error_count++;
          end
          if (out_top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, out_top_value);
            error_count++;
          end
          if (out_depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, out_depth);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        answer_queue.push_back(evaluate_token(in_op, in_number));
        tokens_taken++;
      end
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed tokens, random phases, halting tail.
  // ---------------------------------------------------------------------------
  initial begin
    mix_t mix;
    int   random_count;
    int   phase_len;
    random_count = 0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty print, unused codes, extreme values, wrap both ways
    add_token(OP_PRINT, '0);
    for (int k = 0; k < UNUSED_OPS; k++) add_token(OP_W'(FIRST_UNUSED_OP + k), '1);
    add_token(OP_PUSH, '0);
    add_token(OP_PRINT, '1);
    add_token(OP_PUSH, '1);
    add_token(OP_PRINT, '0);
    add_token(OP_ADD, '0);          // max + 0
    add_token(OP_PUSH, '1);
    add_token(OP_ADD, '0);          // max + max goes negative
    add_token(OP_PRINT, '0);
    add_token(OP_PUSH, NUM_W'(1));
    add_token(OP_SUB, '0);
    add_token(OP_PRINT, '0);
    add_token(OP_PUSH, '1);
    add_token(OP_SUB, '0);          // wraps past the most negative value
    add_token(OP_PRINT, '0);
    add_token(OP_PUSH, '0);
    add_token(OP_SUB, '1);
    add_token(OP_PRINT, '0);
    add_token(OP_PUSH, NUM_W'(7));
    add_token(OP_SUB, '0);          // back to one entry
    add_token(OP_PRINT, '0);
    wait_drained();

    // random phases; each ends with a sender pause until all answers are in
    while (random_count < RANDOM_TOKENS) begin
      mix       = mix_t'($urandom_range(0, 2));
      phase_len = $urandom_range(60, 250);
      for (int k = 0; k < phase_len; k++) begin
        if (add_random_token(mix)) random_count++;
      end
      wait_drained();
    end

    // halt the block once: either underflow or quit, then tokens it ignores
    if ($urandom_range(0, 1)) begin
      while (plan_depth >= 2) add_token($urandom_range(0, 1) ? OP_ADD : OP_SUB, pick_number());
      add_token($urandom_range(0, 1) ? OP_ADD : OP_SUB, pick_number());
    end else begin
      add_token(OP_QUIT, pick_number());
    end
    add_token(OP_QUIT, pick_number());
    add_token(OP_PUSH, pick_number());
    add_token(OP_PRINT, pick_number());
    for (int k = 0; k < 12; k++) add_token(OP_W'($urandom_range(0, (1 << OP_W) - 1)), pick_number());
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
